@@ sv/srlp_pkg.sv @@
// Package of shared constants and helper functions for the stepper reply line parser.
`default_nettype none
package srlp_pkg;

  // Width in which numbers are accumulated before being cut to the 32-bit output fields.
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_FIVE    = 8'h35;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_Y       = 8'h59;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_ACK   = 3'd0;
  localparam kind_t KIND_POS   = 3'd1;
  localparam kind_t KIND_SPEED = 3'd2;
  localparam kind_t KIND_LIMIT = 3'd3;
  localparam kind_t KIND_BOTH  = 3'd4;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [OUT_WIDTH-1:0]   out_value_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Shift-and-add form of acc * 10 + digit, wrapping in VALUE_WIDTH bits.
  function automatic value_t add_digit(input value_t acc, input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return (acc << 3) + (acc << 1) + value_t'(d[3:0]);
  endfunction

  // Sign-extend or truncate from VALUE_WIDTH to the output width.
  function automatic out_value_t to_out(input value_t v);
    logic signed [VALUE_WIDTH-1:0] s;
    s = signed'(v);
    return out_value_t'(s);
  endfunction

endpackage
`default_nettype wire

@@ sv/stepper_reply_line_parser.sv @@
// Stepper reply line parser: byte-wide line recogniser that emits one record per reply line.
//
// Input channel: one received byte per item on in_rx_byte (in_valid / in_stall).
// Byte 10 ends a line. A line opening with '*' yields an ack record; lines of the
// form "X,-1,n", "X,-2,n", "X,5,n" or "X,0,n,m" (or Y) yield position, speed,
// limit-switch or position-plus-speed records. Any other line is dropped.
// Result channel: out_record_kind, out_axis_id, out_first_value, out_second_value
// under out_valid / out_stall; at most one record per line, taken at the newline.
// Latency: the record appears on the outputs the cycle after its newline is taken.
// Throughput: one byte per cycle while in_stall is low; the line state and the record
// register are each updated by short decode logic and a shift-add for the digits.
// When the receiver stalls, the record register holds and in_stall rises only
// while a record waits and is stalled, so bytes keep flowing otherwise.
// Reset (rst_n low, synchronous) returns the parser to the start of a line with
// all numbers cleared and the record register empty.
`default_nettype none
module stepper_reply_line_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_record_kind,
  output logic             out_axis_id,
  output logic [31:0]      out_first_value,
  output logic [31:0]      out_second_value
);

  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_AXIS_COMMA  = 4'd1,
    PH_CODE        = 4'd2,
    PH_NEG_CODE    = 4'd3,
    PH_CODE_COMMA  = 4'd4,
    PH_NUM1_SIGN   = 4'd5,
    PH_NUM1_DIGITS = 4'd6,
    PH_NUM2_SIGN   = 4'd7,
    PH_NUM2_DIGITS = 4'd8,
    PH_TAIL        = 4'd9,
    PH_ACK         = 4'd10,
    PH_SKIP        = 4'd11
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  axis_r, axis_nxt;
  srlp_pkg::kind_t       kind_r, kind_nxt;
  logic                  minus_r, minus_nxt;
  srlp_pkg::value_t      acc_r, acc_nxt;
  srlp_pkg::value_t      held_r, held_nxt;

  logic                  out_valid_r;
  srlp_pkg::kind_t       out_kind_r, out_kind_nxt;
  logic                  out_axis_r, out_axis_nxt;
  srlp_pkg::out_value_t  out_first_r, out_first_nxt;
  srlp_pkg::out_value_t  out_second_r, out_second_nxt;

  logic                  in_take;
  logic                  out_free;
  logic                  emit;
  logic                  digit;
  logic                  newline;
  srlp_pkg::value_t      finished;
  srlp_pkg::value_t      acc_digit;
  srlp_pkg::value_t      first_v, second_v;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !out_free;
  assign in_take   = in_valid && !in_stall;
  assign digit     = srlp_pkg::is_digit(in_rx_byte);
  assign newline   = (in_rx_byte == srlp_pkg::CH_NEWLINE);
  assign finished  = minus_r ? (srlp_pkg::value_t'(0) - acc_r) : acc_r;
  assign acc_digit = srlp_pkg::add_digit(acc_r, in_rx_byte);

  always_comb begin
    phase_nxt = phase_r;
    axis_nxt  = axis_r;
    kind_nxt  = kind_r;
    minus_nxt = minus_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    first_v   = '0;
    second_v  = '0;

    if (newline) begin
      unique case (phase_r)
        PH_NUM1_SIGN, PH_NUM1_DIGITS: begin
          emit    = 1'b1;
          first_v = finished;
        end
        PH_NUM2_SIGN, PH_NUM2_DIGITS: begin
          emit     = 1'b1;
          first_v  = held_r;
          second_v = finished;
        end
        PH_TAIL: begin
          emit    = 1'b1;
          first_v = held_r;
          if (kind_r == srlp_pkg::KIND_BOTH) begin
            second_v = acc_r;
          end
        end
        PH_ACK: begin
          emit = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      phase_nxt = PH_START;
      axis_nxt  = 1'b0;
      kind_nxt  = srlp_pkg::KIND_ACK;
      minus_nxt = 1'b0;
      acc_nxt   = '0;
      held_nxt  = '0;
    end else begin
      unique case (phase_r)
        PH_START: begin
          if (in_rx_byte == srlp_pkg::CH_STAR) begin
            phase_nxt = PH_ACK;
          end else if (in_rx_byte == srlp_pkg::CH_X || in_rx_byte == srlp_pkg::CH_Y) begin
            axis_nxt  = in_rx_byte[0];
            phase_nxt = PH_AXIS_COMMA;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_AXIS_COMMA: begin
          phase_nxt = (in_rx_byte == srlp_pkg::CH_COMMA) ? PH_CODE : PH_SKIP;
        end
        PH_CODE: begin
          if (in_rx_byte == srlp_pkg::CH_MINUS) begin
            phase_nxt = PH_NEG_CODE;
          end else if (in_rx_byte == srlp_pkg::CH_FIVE) begin
            kind_nxt  = srlp_pkg::KIND_LIMIT;
            phase_nxt = PH_CODE_COMMA;
          end else if (in_rx_byte == srlp_pkg::CH_ZERO) begin
            kind_nxt  = srlp_pkg::KIND_BOTH;
            phase_nxt = PH_CODE_COMMA;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_NEG_CODE: begin
          if (in_rx_byte == srlp_pkg::CH_ONE) begin
            kind_nxt  = srlp_pkg::KIND_POS;
            phase_nxt = PH_CODE_COMMA;
          end else if (in_rx_byte == srlp_pkg::CH_TWO) begin
            kind_nxt  = srlp_pkg::KIND_SPEED;
            phase_nxt = PH_CODE_COMMA;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_CODE_COMMA: begin
          phase_nxt = (in_rx_byte == srlp_pkg::CH_COMMA) ? PH_NUM1_SIGN : PH_SKIP;
        end
        PH_NUM1_SIGN, PH_NUM1_DIGITS: begin
          if (phase_r == PH_NUM1_SIGN && in_rx_byte == srlp_pkg::CH_MINUS &&
              kind_r != srlp_pkg::KIND_LIMIT) begin
            minus_nxt = 1'b1;
            phase_nxt = PH_NUM1_DIGITS;
          end else if (digit) begin
            acc_nxt   = acc_digit;
            phase_nxt = PH_NUM1_DIGITS;
          end else begin
            // end of first number: store it, clear for the second
            held_nxt  = finished;
            acc_nxt   = '0;
            minus_nxt = 1'b0;
            phase_nxt = (kind_r == srlp_pkg::KIND_BOTH) ? PH_NUM2_SIGN : PH_TAIL;
          end
        end
        PH_NUM2_SIGN, PH_NUM2_DIGITS: begin
          if (phase_r == PH_NUM2_SIGN && in_rx_byte == srlp_pkg::CH_MINUS) begin
            minus_nxt = 1'b1;
            phase_nxt = PH_NUM2_DIGITS;
          end else if (digit) begin
            acc_nxt   = acc_digit;
            phase_nxt = PH_NUM2_DIGITS;
          end else begin
            acc_nxt   = finished;
            minus_nxt = 1'b0;
            phase_nxt = PH_TAIL;
          end
        end
        PH_TAIL, PH_ACK: begin
          phase_nxt = phase_r;
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
    end
  end

  always_comb begin
    if (phase_r == PH_ACK) begin
      out_kind_nxt   = srlp_pkg::KIND_ACK;
      out_axis_nxt   = 1'b0;
      out_first_nxt  = '0;
      out_second_nxt = '0;
    end else begin
      out_kind_nxt   = kind_r;
      out_axis_nxt   = axis_r;
      out_first_nxt  = srlp_pkg::to_out(first_v);
      out_second_nxt = srlp_pkg::to_out(second_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      axis_r      <= 1'b0;
      kind_r      <= srlp_pkg::KIND_ACK;
      minus_r     <= 1'b0;
      acc_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        phase_r <= phase_nxt;
        axis_r  <= axis_nxt;
        kind_r  <= kind_nxt;
        minus_r <= minus_nxt;
        acc_r   <= acc_nxt;
        held_r  <= held_nxt;
      end
      // load a new record, or drop the one just taken
      if (out_free) begin
        out_valid_r <= in_take && emit;
      end
      if (out_free && in_take && emit) begin
        out_kind_r   <= out_kind_nxt;
        out_axis_r   <= out_axis_nxt;
        out_first_r  <= out_first_nxt;
        out_second_r <= out_second_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = out_kind_r;
  assign out_axis_id      = out_axis_r;
  assign out_first_value  = out_first_r;
  assign out_second_value = out_second_r;

  a_no_record_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !newline && out_free) |=> !out_valid)
    else $error("record produced by a byte that does not end a line");

  a_newline_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && newline) |=> (phase_r == PH_START && acc_r == '0 && held_r == '0))
    else $error("line state not cleared after newline");

  a_ack_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind == srlp_pkg::KIND_ACK) |->
      (!out_axis_id && out_first_value == '0 && out_second_value == '0))
    else $error("ack record carries non-zero fields");

  a_second_only_both: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind != srlp_pkg::KIND_BOTH) |-> out_second_value == '0)
    else $error("second value set on a single-value record");

endmodule
`default_nettype wire
